// ===== hw/rtl/stable_priority_queue_macros.svh =====
// Assertion macros for the stable priority queue.
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold on every clock edge out of reset.
`define SPQ_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SPQ_ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/spq_pkg.sv =====
package spq_pkg;

	// Command codes
	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_ENQUEUED = 2'd0;
	localparam logic [1:0] ST_DEQUEUED = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam int unsigned NUM_PRIO = 4;

	// Request transaction
	typedef struct packed {
		logic        cmd;
		logic [15:0] asset_id;
		logic [1:0]  priority_req;
		logic [31:0] complaint_stamp;
	} req_item_t;

	// Response transaction
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_asset_id;
		logic [1:0]  out_priority;
		logic [31:0] out_stamp;
		logic [4:0]  occupancy;
	} rsp_item_t;

	// Stored payload; the priority is implied by the memory bank
	typedef struct packed {
		logic [15:0] asset_id;
		logic [31:0] stamp;
	} entry_t;

endpackage

// ===== hw/rtl/stable_priority_queue.sv =====
// Channel | Handshake            | Payload     | Moves
// --------+----------------------+-------------+-------------------------------
// req     | req_valid/req_ready  | req_item_t  | enqueue or dequeue command
// rsp     | rsp_valid/rsp_ready  | rsp_item_t  | one status transaction per req
//
// Enqueue and empty/full results are written straight into the output register; a dequeue
// with data first passes the registered read port of the entry memory, then that register.
// The memory holds one ring of DEPTH slots per priority level; counters and
// ring pointers reset to empty, memory contents are not cleared.
// A result waits in the output register; a new request is taken when that
// register is empty or draining, except in the cycle after a dequeue with data.
`include "stable_priority_queue_macros.svh"

module stable_priority_queue import spq_pkg::*; #(
	parameter int unsigned DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW    = $clog2(DEPTH + 1);
	localparam int unsigned AW    = PW + 2;
	localparam int unsigned MSIZE = NUM_PRIO << PW;
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	// Per-priority ring state and total count
	logic [CW-1:0] cnt_q [NUM_PRIO];
	logic [PW-1:0] head_q [NUM_PRIO];
	logic [PW-1:0] tail_q [NUM_PRIO];
	logic [CW-1:0] total_q;

	// Entry memory and read stage
	entry_t        mem [MSIZE];
	entry_t        rdata_s1;
	logic          rd_pend_s1;
	logic [1:0]    prio_s1;
	logic [CW-1:0] occ_s1;

	logic          rsp_valid_q;
	rsp_item_t     rsp_q;

	logic          accept;
	logic          is_enq;
	logic          full;
	logic          empty;
	logic          do_enq;
	logic          do_deq;
	logic [1:0]    deq_prio;
	logic [1:0]    enq_prio;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [CW-1:0] total_nxt;
	logic [CW+4:0] occ_wide;
	logic [CW+4:0] occ_s1_wide;

	assign accept    = req_valid && req_ready;
	assign req_ready = !rd_pend_s1 && (!rsp_valid_q || rsp_ready);
	assign is_enq    = (req.cmd == CMD_ENQ);
	assign full      = (total_q == FULL_CNT);
	assign empty     = (total_q == '0);
	assign do_enq    = accept && is_enq && !full;
	assign do_deq    = accept && !is_enq && !empty;
	assign enq_prio  = req.priority_req;

	// Lowest nonempty priority level is the queue front
	always_comb begin
		deq_prio = '0;
		for (int i = NUM_PRIO - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0) begin
				deq_prio = 2'(i);
			end
		end
	end

	assign waddr = {enq_prio, tail_q[enq_prio]};
	assign raddr = {deq_prio, head_q[deq_prio]};

	always_comb begin
		total_nxt = total_q;
		if (do_enq) begin
			total_nxt = total_q + CW'(1);
		end else if (do_deq) begin
			total_nxt = total_q - CW'(1);
		end
	end

	assign occ_wide    = {5'b0, total_nxt};
	assign occ_s1_wide = {5'b0, occ_s1};

	// Entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (do_enq) begin
			mem[waddr] <= '{asset_id: req.asset_id, stamp: req.complaint_stamp};
		end
		if (do_deq) begin
			rdata_s1 <= mem[raddr];
		end
	end

	// Ring pointers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PRIO; i++) begin
				cnt_q[i]  <= '0;
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
			total_q <= '0;
		end else begin
			total_q <= total_nxt;
			for (int i = 0; i < NUM_PRIO; i++) begin
				if (do_enq && enq_prio == 2'(i)) begin
					cnt_q[i]  <= cnt_q[i] + CW'(1);
					tail_q[i] <= (tail_q[i] == LAST_SLOT) ? '0 : tail_q[i] + PW'(1);
				end
				if (do_deq && deq_prio == 2'(i)) begin
					cnt_q[i]  <= cnt_q[i] - CW'(1);
					head_q[i] <= (head_q[i] == LAST_SLOT) ? '0 : head_q[i] + PW'(1);
				end
			end
		end
	end

	// Read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= do_deq;
		end
	end

	always_ff @(posedge clk) begin
		if (do_deq) begin
			prio_s1 <= deq_prio;
			occ_s1  <= total_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rd_pend_s1 || (accept && !do_deq)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			rsp_q.status       <= ST_DEQUEUED;
			rsp_q.out_asset_id <= rdata_s1.asset_id;
			rsp_q.out_priority <= prio_s1;
			rsp_q.out_stamp    <= rdata_s1.stamp;
			rsp_q.occupancy    <= occ_s1_wide[4:0];
		end else if (accept && !do_deq) begin
			if (is_enq) begin
				rsp_q.status <= full ? ST_FULL : ST_ENQUEUED;
			end else begin
				rsp_q.status <= ST_EMPTY;
			end
			rsp_q.out_asset_id <= '0;
			rsp_q.out_priority <= '0;
			rsp_q.out_stamp    <= '0;
			rsp_q.occupancy    <= occ_wide[4:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	`SPQ_ASSERT_ALWAYS(a_total_bound, clk, arst_n, total_q <= FULL_CNT, "count above depth")
	`SPQ_ASSERT_ALWAYS(a_total_sum, clk, arst_n,
		(CW+2)'(total_q) == (CW+2)'(cnt_q[0]) + (CW+2)'(cnt_q[1]) +
		(CW+2)'(cnt_q[2]) + (CW+2)'(cnt_q[3]),
		"level counts disagree with total")
	`SPQ_ASSERT_NEXT(a_read_lands, clk, arst_n, rd_pend_s1,
		rsp_valid && rsp.status == ST_DEQUEUED, "read data not presented")
	`SPQ_ASSERT_NEXT(a_empty_deq, clk, arst_n, accept && !is_enq && empty,
		rsp_valid && rsp.status == ST_EMPTY && rsp.occupancy == 5'd0,
		"empty dequeue misreported")

endmodule

// ===== tb/tb_top.sv =====
module tb_top import spq_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH          = 16;
	localparam int unsigned RANDOM_ITEMS   = 1300;
	localparam int unsigned STALL_LIMIT    = 2000;
	localparam int unsigned MAX_REPORTS    = 10;
	localparam int unsigned DRAIN_CYCLES   = 10;

	// One held request, kept in service order by the predictor
	typedef struct packed {
		logic [15:0] asset;
		logic [1:0]  prio;
		logic [31:0] stamp;
	} ticket_t;

	// One line of the directed stimulus
	typedef struct {
		req_item_t req;
		bit        typed;
		rsp_item_t rsp;
	} plan_row_t;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_item_t rsp;

	ticket_t     held_tickets[$];
	rsp_item_t   awaited_rsp[$];
	int unsigned fail_count;
	int unsigned quiet_cycles;
	bit          send_gaps;
	bit          recv_gaps;

	stable_priority_queue #(
		.DEPTH(DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Queue behavior: insert after all entries of equal or better priority, pop the front
	function automatic rsp_item_t serve_request(req_item_t r);
		rsp_item_t o;
		ticket_t   t;
		int        pos;
		o = '0;
		if (r.cmd == CMD_ENQ) begin
			if (held_tickets.size() >= DEPTH) begin
				o.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < held_tickets.size() && held_tickets[pos].prio <= r.priority_req)
					pos++;
				t = '{r.asset_id, r.priority_req, r.complaint_stamp};
				held_tickets.insert(pos, t);
				o.status = ST_ENQUEUED;
			end
		end else if (held_tickets.size() == 0) begin
			o.status = ST_EMPTY;
		end else begin
			t = held_tickets.pop_front();
			o.status       = ST_DEQUEUED;
			o.out_asset_id = t.asset;
			o.out_priority = t.prio;
			o.out_stamp    = t.stamp;
		end
		o.occupancy = 5'(held_tickets.size());
		return o;
	endfunction

	// Mostly back-to-back, some short gaps, a few long ones
	function automatic int unsigned pick_gap(bit enabled);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic plan_row_t enq_row(logic [15:0] asset, logic [1:0] prio,
			logic [31:0] stamp);
		plan_row_t row;
		row.req   = '{CMD_ENQ, asset, prio, stamp};
		row.typed = 1'b0;
		row.rsp   = '0;
		return row;
	endfunction

	function automatic plan_row_t deq_row();
		plan_row_t row;
		row.req   = '0;
		row.req.cmd = CMD_DEQ;
		row.typed = 1'b0;
		row.rsp   = '0;
		return row;
	endfunction

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%t ERROR: %s", $realtime, msg);
	endtask

	// Present one transaction and hold it until accepted; then log its expected response
	task automatic send_request(req_item_t item, bit typed, rsp_item_t typed_rsp);
		int unsigned gap;
		rsp_item_t   predicted;
		gap = pick_gap(send_gaps);
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
		predicted = serve_request(item);
		awaited_rsp.push_back(typed ? typed_rsp : predicted);
	endtask

	// Hold off the sender until every outstanding response is back
	task automatic wait_until_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0) @(negedge clk);
	endtask

	// Response side: ready with random stalls
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		rsp_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap(recv_gaps);
			end
		end
	end

	// Response checker
	always @(posedge clk) begin : check_rsp
		rsp_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_rsp.size() == 0) begin
				note_failure($sformatf("response with nothing pending: st=%0d asset=%h prio=%0d stamp=%h occ=%0d",
					rsp.status, rsp.out_asset_id, rsp.out_priority, rsp.out_stamp,
					rsp.occupancy));
			end else begin
				want = awaited_rsp.pop_front();
				if (rsp.status !== want.status || rsp.out_asset_id !== want.out_asset_id ||
						rsp.out_priority !== want.out_priority ||
						rsp.out_stamp !== want.out_stamp || rsp.occupancy !== want.occupancy)
					note_failure($sformatf({"mismatch: exp st=%0d asset=%h prio=%0d stamp=%h occ=%0d",
						" / got st=%0d asset=%h prio=%0d stamp=%h occ=%0d"},
						want.status, want.out_asset_id, want.out_priority, want.out_stamp,
						want.occupancy, rsp.status, rsp.out_asset_id, rsp.out_priority,
						rsp.out_stamp, rsp.occupancy));
			end
		end
	end

	// Watchdog: too long with no transaction on either channel
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus
	initial begin
		plan_row_t   plan[$];
		plan_row_t   row;
		req_item_t   item;
		int unsigned phase_left;
		int unsigned enq_pct;
		int unsigned prio_mode;
		logic [1:0]  fixed_prio;

		fail_count   = 0;
		quiet_cycles = 0;
		send_gaps    = 1'b1;
		recv_gaps    = 1'b1;
		req_valid    = 1'b0;
		req          = '0;
		arst_n       = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: dequeue on empty, fill with extremes and ties, overflow, partial drain
		row = deq_row();
		row.typed = 1'b1;
		row.rsp   = '{ST_EMPTY, 16'h0000, 2'd0, 32'h0000_0000, 5'd0};
		plan.push_back(row);
		plan.push_back(enq_row(16'hFFFF, 2'd3, 32'hFFFF_FFFF));
		plan.push_back(enq_row(16'h0000, 2'd0, 32'h0000_0000));
		plan.push_back(enq_row(16'h0001, 2'd3, 32'h0000_0001));
		plan.push_back(enq_row(16'h8000, 2'd0, 32'h8000_0000));
		for (int i = 0; i < 12; i++)
			plan.push_back(enq_row(16'h1000 + 16'(i), 2'((i * 3) % 4), 32'hA5A5_0000 + 32'(i)));
		row = enq_row(16'hABCD, 2'd0, 32'h1234_5678);
		row.typed = 1'b1;
		row.rsp   = '{ST_FULL, 16'h0000, 2'd0, 32'h0000_0000, 5'(DEPTH)};
		plan.push_back(row);
		repeat (6) plan.push_back(deq_row());

		foreach (plan[i])
			send_request(plan[i].req, plan[i].typed, plan[i].rsp);
		wait_until_drained();

		// Random: phases that lean toward filling, draining or balance
		phase_left = 0;
		enq_pct    = 50;
		prio_mode  = 0;
		fixed_prio = 2'd0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2)
				wait_until_drained();
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 60);
				case ($urandom_range(0, 2))
					0: enq_pct = 85;
					1: enq_pct = 15;
					default: enq_pct = 50;
				endcase
				prio_mode  = $urandom_range(0, 3);
				fixed_prio = 2'($urandom_range(0, 3));
				send_gaps  = ($urandom_range(0, 3) != 0);
				recv_gaps  = ($urandom_range(0, 3) != 0);
			end
			phase_left--;

			item.cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
			case (prio_mode)
				1: item.priority_req = fixed_prio;
				2: item.priority_req = $urandom_range(0, 1) ? 2'd3 : 2'd0;
				default: item.priority_req = 2'($urandom_range(0, 3));
			endcase
			case ($urandom_range(0, 15))
				0: item.asset_id = 16'h0000;
				1: item.asset_id = 16'hFFFF;
				default: item.asset_id = 16'($urandom_range(0, 65535));
			endcase
			item.complaint_stamp = $urandom();
			send_request(item, 1'b0, '0);
		end

		// Wind down
		@(negedge clk);
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
